// ----- rtl/core/tga_rle_pixel_decoder_assert.svh -----
// Assertion shorthands for the run-length pixel decoder.
// Every macro samples on i_clk and is quiet while i_rst_n is low.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// Condition that must hold at every clock edge
`define TGA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define TGA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/tga_rle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

    // Configuration port shape and register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MODE   = 2'd2;

    // Packet header coding: top bit set means a run packet
    localparam logic [7:0] RUN_BIAS = 8'd127;

    // Last byte slot of a pixel for each depth
    localparam logic [1:0] SLOT_LAST_RGB  = 2'd2;
    localparam logic [1:0] SLOT_LAST_RGBA = 2'd3;

    // Cycles the pixel accounting needs to settle after a register write
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    // Default depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH_DEF = 2;

    // One finished pixel request from the parser to the output stage
    typedef struct packed {
        logic [23:0] pix;        // stored bytes: blue, green, red (red in four-byte mode only)
        logic [7:0]  last_byte;  // byte that completed the pixel
        logic        use_alpha;  // four-byte pixel
        logic [7:0]  count;
        logic [31:0] first;
        logic        done;
        logic        overrun;
    } t_pix_rec;

endpackage

`default_nettype wire

// ----- rtl/core/tga_rle_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_pixel_decoder_assert.svh"

module tga_rle_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output tga_rle_pkg::t_pix_rec              o_q_rec
);
    import tga_rle_pkg::*;

    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_alpha, n_alpha;
    logic [31:0] r_total;
    logic [1:0]  r_cfg_pend, n_cfg_pend;
    logic        r_expect_hdr, n_expect_hdr;
    logic        r_run, n_run;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic [1:0]  r_slot, n_slot;
    logic [23:0] r_pix, n_pix;
    logic [31:0] r_pix_done, n_pix_done;
    logic [31:0] r_rem, n_rem;

    logic        accept, store, complete;
    logic [1:0]  last_slot;
    logic [7:0]  hdr_len;
    logic        rem_small;
    logic [7:0]  rem_lo;
    logic        run_over, run_done, raw_done;
    logic [7:0]  run_count, pkt_dec;
    logic [7:0]  count;
    logic        done, overrun;
    logic        rem_ok, done_push;

    // Handshakes: hold input while the accounting settles or the queue is full
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_cfg_pend == 2'd0) && !i_q_full;
    assign accept      = i_in_valid && o_in_ready;

    // Classify the byte
    assign last_slot = r_alpha ? SLOT_LAST_RGBA : SLOT_LAST_RGB;
    assign store     = !r_expect_hdr && (r_slot < last_slot);
    assign complete  = !r_expect_hdr && !store;
    assign hdr_len   = i_data_byte[7] ? (i_data_byte - RUN_BIAS) : (i_data_byte + 8'd1);

    // Clip against the pixels left in the image
    assign rem_small = (r_rem[31:8] == 24'd0);
    assign rem_lo    = r_rem[7:0];
    assign run_over  = rem_small && (rem_lo < r_pkt_left);
    assign run_done  = rem_small && (rem_lo <= r_pkt_left);
    assign run_count = run_over ? rem_lo : r_pkt_left;
    assign raw_done  = (r_rem == 32'd1);
    assign pkt_dec   = r_pkt_left - 8'd1;

    assign count   = r_run ? run_count : 8'd1;
    assign done    = r_run ? run_done : raw_done;
    assign overrun = r_run ? run_over : (raw_done && (pkt_dec != 8'd0));

    // Pass finished pixels on
    assign o_q_push          = accept && complete;
    assign o_q_rec.pix       = r_pix;
    assign o_q_rec.last_byte = i_data_byte;
    assign o_q_rec.use_alpha = r_alpha;
    assign o_q_rec.count     = count;
    assign o_q_rec.first     = r_pix_done;
    assign o_q_rec.done      = done;
    assign o_q_rec.overrun   = overrun;

    // Next state
    always_comb begin
        n_width      = r_width;
        n_height     = r_height;
        n_alpha      = r_alpha;
        n_cfg_pend   = r_cfg_pend;
        n_expect_hdr = r_expect_hdr;
        n_run        = r_run;
        n_pkt_left   = r_pkt_left;
        n_slot       = r_slot;
        n_pix        = r_pix;
        n_pix_done   = r_pix_done;
        n_rem        = r_rem;

        // Register writes restart the settle countdown
        if (i_cfg_valid) begin
            n_cfg_pend = CFG_SETTLE;
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_width  = i_cfg_data;
                CFG_IMAGE_HEIGHT: n_height = i_cfg_data;
                CFG_ALPHA_MODE:   n_alpha  = i_cfg_data[0];
                default: ;
            endcase
        end else if (r_cfg_pend != 2'd0) begin
            n_cfg_pend = r_cfg_pend - 2'd1;
            // Recompute pixels left once the new total is registered
            if (r_cfg_pend == 2'd1) begin
                n_rem = (r_pix_done < r_total) ? (r_total - r_pix_done) : 32'd1;
            end
        end

        if (accept) begin
            if (r_expect_hdr) begin
                n_run        = i_data_byte[7];
                n_pkt_left   = hdr_len;
                n_expect_hdr = 1'b0;
                n_slot       = 2'd0;
            end else if (store) begin
                case (r_slot)
                    2'd0:    n_pix[7:0]   = i_data_byte;
                    2'd1:    n_pix[15:8]  = i_data_byte;
                    2'd2:    n_pix[23:16] = i_data_byte;
                    default: ;
                endcase
                n_slot = r_slot + 2'd1;
            end else begin
                n_slot = 2'd0;
                if (r_run) begin
                    n_pkt_left   = 8'd0;
                    n_expect_hdr = 1'b1;
                end else begin
                    n_pkt_left   = done ? 8'd0 : pkt_dec;
                    n_expect_hdr = done || (pkt_dec == 8'd0);
                end
                // Advance the image position, rewind at the image end
                if (done) begin
                    n_pix_done = 32'd0;
                    n_rem      = r_total;
                end else begin
                    n_pix_done = r_pix_done + {24'd0, count};
                    n_rem      = r_rem - {24'd0, count};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= 16'd1;
            r_height     <= 16'd1;
            r_alpha      <= 1'b0;
            r_total      <= 32'd1;
            r_cfg_pend   <= 2'd0;
            r_expect_hdr <= 1'b1;
            r_run        <= 1'b0;
            r_pkt_left   <= 8'd0;
            r_slot       <= 2'd0;
            r_pix        <= 24'd0;
            r_pix_done   <= 32'd0;
            r_rem        <= 32'd1;
        end else begin
            r_width      <= n_width;
            r_height     <= n_height;
            r_alpha      <= n_alpha;
            // An empty image counts as one pixel
            r_total      <= ((r_width == 16'd0) || (r_height == 16'd0)) ? 32'd1 :
                            ({16'd0, r_width} * {16'd0, r_height});
            r_cfg_pend   <= n_cfg_pend;
            r_expect_hdr <= n_expect_hdr;
            r_run        <= n_run;
            r_pkt_left   <= n_pkt_left;
            r_slot       <= n_slot;
            r_pix        <= n_pix;
            r_pix_done   <= n_pix_done;
            r_rem        <= n_rem;
        end
    end

    // Pixels left must match the image position once settled, unless clamped to one
    assign rem_ok    = (r_cfg_pend != 2'd0) || (r_rem == 32'd1) ||
                       ((r_pix_done + r_rem) == r_total);
    assign done_push = o_q_push && o_q_rec.done;

    `TGA_ASSERT_ALWAYS(a_rem_nonzero, r_rem != 32'd0, "pixels left dropped to zero")
    `TGA_ASSERT_ALWAYS(a_rem_consistent, rem_ok, "pixels left disagrees with image position")
    `TGA_ASSERT_NEXT(a_done_rewinds, done_push, (r_pix_done == 32'd0) && r_expect_hdr, "no rewind")

endmodule

`default_nettype wire

// ----- rtl/core/tga_rle_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_pixel_decoder_assert.svh"

module tga_rle_fifo #(
    parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tga_rle_pkg::t_pix_rec i_rec,
    output logic                  o_full,
    output logic                  o_valid,
    output tga_rle_pkg::t_pix_rec o_rec,
    input  logic                  i_pop
);
    import tga_rle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_pix_rec        r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    `TGA_ASSERT_ALWAYS(a_no_push_full, !(i_push && o_full), "push into full queue")
    `TGA_ASSERT_ALWAYS(a_no_pop_empty, !(i_pop && !o_valid), "pop from empty queue")
    `TGA_ASSERT_ALWAYS(a_count_range, r_count <= CW'(DEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ----- rtl/core/tga_rle_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  tga_rle_pkg::t_pix_rec i_q_rec,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_alpha,
    output logic [7:0]            o_repeat_count,
    output logic [31:0]           o_first_index,
    output logic                  o_image_done,
    output logic                  o_overrun
);
    import tga_rle_pkg::*;

    logic        r_valid;
    logic [7:0]  r_red, r_green, r_blue, r_alpha, r_count;
    logic [31:0] r_first;
    logic        r_done, r_overrun;

    // Take a request when the output register is free or being drained
    assign o_q_pop = i_q_valid && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Reorder stored blue, green, red (, alpha) into red, green, blue, alpha
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_red     <= i_q_rec.use_alpha ? i_q_rec.pix[23:16] : i_q_rec.last_byte;
            r_green   <= i_q_rec.pix[15:8];
            r_blue    <= i_q_rec.pix[7:0];
            r_alpha   <= i_q_rec.use_alpha ? i_q_rec.last_byte : 8'd0;
            r_count   <= i_q_rec.count;
            r_first   <= i_q_rec.first;
            r_done    <= i_q_rec.done;
            r_overrun <= i_q_rec.overrun;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_alpha        = r_alpha;
    assign o_repeat_count = r_count;
    assign o_first_index  = r_first;
    assign o_image_done   = r_done;
    assign o_overrun      = r_overrun;

endmodule

`default_nettype wire

// ----- rtl/core/tga_rle_pixel_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Run-length pixel decoder for 24 and 32 bit TGA image data.
// Input channel (i_in_valid / o_in_ready, i_data_byte): one byte of the
// coded stream per request, packet headers and pixel bytes alike.
// Output channel (o_out_valid / i_out_ready): one request per raw pixel and
// one per run packet, colour as red, green, blue, alpha, with repeat count,
// first pixel index, image-end and overrun flags.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
// index 0 image width, 1 image height, 2 alpha mode; write while idle.
// Throughput: one byte per cycle while the queue has room and no register
// write is settling. The byte that completes a pixel lands in the queue; the
// output register loads from the queue head when it is free or being drained.
// After a register write the input holds o_in_ready low while the settle
// countdown runs and the image size product and pixels-left counter update.
// A stalled output keeps its result; parsing goes on until the queue
// fills, then o_in_ready drops.
// Reset: width 1, height 1, 24 bit mode, a packet header expected next,
// image position zero, queue and output empty.

module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic [7:0]                         o_alpha,
    output logic [7:0]                         o_repeat_count,
    output logic [31:0]                        o_first_index,
    output logic                               o_image_done,
    output logic                               o_overrun
);
    import tga_rle_pkg::*;

    logic     q_push, q_full, q_valid, q_pop;
    t_pix_rec q_wr_rec, q_rd_rec;

    // Parse bytes and track the image position
    tga_rle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_rec     (q_wr_rec)
    );

    // Decouple parser from output stalls
    tga_rle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_wr_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rd_rec),
        .i_pop   (q_pop)
    );

    // Format and hold results
    tga_rle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_rec        (q_rd_rec),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_repeat_count (o_repeat_count),
        .o_first_index  (o_first_index),
        .o_image_done   (o_image_done),
        .o_overrun      (o_overrun)
    );

endmodule

`default_nettype wire
